>>> rtl/ivcs_pkg.sv
// ----------------------------------------------------------------------------
// ivcs_pkg
// Shared types and constants of the integer value counting set.
// ----------------------------------------------------------------------------
package ivcs_pkg;

	localparam int ENTRIES  = 16384;
	localparam int ADDR_W   = $clog2(ENTRIES);
	localparam int SIZE_W   = ADDR_W + 1;
	localparam int ARW      = (ADDR_W + 2 > 18) ? ADDR_W + 2 : 18;
	localparam int CNT_W    = 32;
	localparam int VAL_W    = 16;
	localparam int RANK_W   = 14;
	localparam int DIST_W   = 15;
	localparam int REQ_W    = 2;
	localparam int STAT_W   = 2;

	localparam int S_TDATA_W = 32;
	localparam int M_RES_W   = STAT_W + 1 + CNT_W + VAL_W + DIST_W;
	localparam int M_TDATA_W = ((M_RES_W + 7) / 8) * 8;

	localparam logic [CNT_W-1:0]  COUNT_MAX    = '1;
	localparam logic [DIST_W-1:0] DISTINCT_MAX = '1;

	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SELECT = 2'd2;
	localparam logic [REQ_W-1:0] REQ_RSVD   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OUTSIDE  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

	localparam logic CFG_VALUE_MIN = 1'b0;
	localparam logic CFG_VALUE_MAX = 1'b1;

	localparam logic signed [VAL_W-1:0] VALUE_MIN_RST = -16'sd5000;
	localparam logic signed [VAL_W-1:0] VALUE_MAX_RST = 16'sd5000;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [DIST_W-1:0]       distinct_seen;
		logic signed [VAL_W-1:0] found_value;
		logic [CNT_W-1:0]        occurrences;
		logic                    is_new;
		logic [STAT_W-1:0]       status;
	} res_t;

endpackage

>>> rtl/ivcs_ram.sv
// ----------------------------------------------------------------------------
// ivcs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ivcs_ram #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/ivcs_core.sv
// ----------------------------------------------------------------------------
// ivcs_core
// Request sequencer: count read-modify-write, rank walk and clearing pass.
// ----------------------------------------------------------------------------
module ivcs_core
	import ivcs_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [VAL_W-1:0] value_min,
	input  logic signed [VAL_W-1:0] value_max,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [REQ_W-1:0]        req_type,
	input  logic signed [VAL_W-1:0] value,
	input  logic [RANK_W-1:0]       rank,
	input  logic                    out_free,
	output logic                    res_valid,
	output res_t                    res
);

	localparam logic signed [ARW-1:0] ENTRIES_S = ARW'(ENTRIES);
	localparam logic [ADDR_W-1:0]     CLR_LAST  = ADDR_W'(ENTRIES - 1);

	state_t state_q, state_d;

	logic signed [ARW-1:0] span_c, off_c, size_ext_c;
	logic [SIZE_W-1:0]     size_c;
	logic                  inwin_c, accept, walk_start_c;

	logic [ADDR_W-1:0]     clr_q;
	logic [DIST_W-1:0]     distinct_q, distinct_d;

	logic [REQ_W-1:0]      req_s1;
	logic                  inwin_s1, direct_hit_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [RANK_W-1:0]     rank_s1;
	logic [SIZE_W-1:0]     size_q;

	logic [SIZE_W-1:0]     walk_addr_q;
	logic [RANK_W-1:0]     passed_q;
	logic                  rd_vld_s1;
	logic [ADDR_W-1:0]     slot_s1;
	logic                  walk_issue, walk_nz, walk_hit, walk_miss;

	logic [STAT_W-1:0]       stat_q;
	logic signed [VAL_W-1:0] found_q;

	logic                  mem_we, mem_re;
	logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
	logic [CNT_W-1:0]      mem_wdata, mem_rdata, cnt_inc;
	logic                  add_hit, exec_done;

	// window arithmetic
	always_comb begin
		span_c = {{(ARW-VAL_W){value_max[VAL_W-1]}}, value_max}
		       - {{(ARW-VAL_W){value_min[VAL_W-1]}}, value_min}
		       + ARW'(1);
		if (span_c <= 0) begin
			size_c = '0;
		end else if (span_c > ENTRIES_S) begin
			size_c = SIZE_W'(ENTRIES);
		end else begin
			size_c = span_c[SIZE_W-1:0];
		end
		size_ext_c = signed'({{(ARW-SIZE_W){1'b0}}, size_c});
		off_c = {{(ARW-VAL_W){value[VAL_W-1]}}, value}
		      - {{(ARW-VAL_W){value_min[VAL_W-1]}}, value_min};
		inwin_c = !off_c[ARW-1] && (off_c < size_ext_c);
	end

	assign accept       = in_valid && in_ready;
	assign walk_start_c = (req_type == REQ_SELECT) && (ARW'(distinct_q) < ARW'(size_c));

	// rank walk over the store, one slot read per cycle
	assign walk_nz    = rd_vld_s1 && (mem_rdata != '0);
	assign walk_hit   = walk_nz && (passed_q == rank_s1);
	assign walk_issue = (state_q == S_WALK) && (walk_addr_q < size_q) && !walk_hit;
	assign walk_miss  = (state_q == S_WALK) && !rd_vld_s1 && !(walk_addr_q < size_q);

	assign add_hit   = (req_s1 == REQ_ADD) && inwin_s1;
	assign exec_done = (state_q == S_EXEC) && out_free;
	assign cnt_inc   = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + CNT_W'(1);

	always_comb begin
		distinct_d = distinct_q;
		if (add_hit && (mem_rdata == '0) && (distinct_q != DISTINCT_MAX)) begin
			distinct_d = distinct_q + DIST_W'(1);
		end
	end

	// memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = cnt_inc;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (exec_done && add_hit) begin
			mem_we = 1'b1;
		end
		mem_re    = accept || walk_issue;
		mem_raddr = (state_q == S_WALK) ? walk_addr_q[ADDR_W-1:0] : off_c[ADDR_W-1:0];
	end

	ivcs_ram #(
		.DEPTH(ENTRIES),
		.WIDTH(CNT_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) state_d = walk_start_c ? S_WALK : S_EXEC;
			end
			S_EXEC: begin
				if (out_free) state_d = S_IDLE;
			end
			S_WALK: begin
				if (walk_hit || walk_miss) state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		res_valid = 1'b0;
		res       = '0;
		res.distinct_seen = distinct_q;
		if (state_q == S_EXEC) begin
			res_valid = out_free;
			res.distinct_seen = distinct_d;
			unique case (req_s1)
				REQ_ADD: begin
					if (inwin_s1) begin
						res.is_new      = (mem_rdata == '0);
						res.occurrences = cnt_inc;
					end else begin
						res.status = STAT_OUTSIDE;
					end
				end
				REQ_QUERY: begin
					if (inwin_s1) res.occurrences = mem_rdata;
					else          res.status      = STAT_OUTSIDE;
				end
				REQ_SELECT: begin
					if (direct_hit_s1) res.found_value = value_min + 16'(rank_s1);
					else               res.status      = STAT_NOTFOUND;
				end
				REQ_RSVD: begin
					res.status = STAT_OK;
				end
			endcase
		end else if (state_q == S_RESP) begin
			res_valid       = out_free;
			res.status      = stat_q;
			res.found_value = found_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			distinct_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (exec_done) distinct_q <= distinct_d;
			rd_vld_s1 <= walk_issue;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1        <= req_type;
			inwin_s1      <= inwin_c;
			addr_s1       <= off_c[ADDR_W-1:0];
			rank_s1       <= rank;
			size_q        <= size_c;
			direct_hit_s1 <= ARW'(rank) < ARW'(size_c);
			walk_addr_q   <= '0;
			passed_q      <= '0;
		end
		if (walk_issue) begin
			walk_addr_q <= walk_addr_q + SIZE_W'(1);
			slot_s1     <= walk_addr_q[ADDR_W-1:0];
		end
		if (walk_nz && !walk_hit) passed_q <= passed_q + RANK_W'(1);
		if (state_q == S_WALK) begin
			if (walk_hit) begin
				stat_q  <= STAT_OK;
				found_q <= value_min + 16'(slot_s1);
			end else if (walk_miss) begin
				stat_q  <= STAT_NOTFOUND;
				found_q <= '0;
			end
		end
	end

	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("item taken during clearing pass");

	a_write_only_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != S_CLEAR) |-> (state_q == S_EXEC && req_s1 == REQ_ADD && out_free))
		else $error("count written outside an add");

	a_walk_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		walk_issue |-> (walk_addr_q < size_q))
		else $error("walk read beyond window");

	a_distinct_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |=> (distinct_q >= $past(distinct_q)))
		else $error("distinct count went down");

	a_walk_data_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == S_WALK))
		else $error("walk data without a walk read");

endmodule

>>> rtl/ivcs_out.sv
// ----------------------------------------------------------------------------
// ivcs_out
// Result register in front of the master stream port.
// ----------------------------------------------------------------------------
module ivcs_out
	import ivcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	input  res_t                 res,
	output logic                 out_free,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic                 vld_q;
	logic [M_TDATA_W-1:0] data_q;

	assign out_free = !vld_q || m_tready;
	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res_valid) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			data_q <= {{(M_TDATA_W-M_RES_W){1'b0}}, res};
		end
	end

endmodule

>>> rtl/integer_value_counting_set.sv
// ----------------------------------------------------------------------------
// integer_value_counting_set
// Occurrence counts per value in a window, distinct count and rank select.
// ----------------------------------------------------------------------------
// Add, query and direct select: the store is read as the item is accepted; in
// S_EXEC, once out_free is high, an add writes its count back and the result goes
// to the output register. No new item is taken until then (s_tready low).
// Walking select: one store slot read per cycle until a hit or the window end.
// Reset: arst_n clears control at once, then a clearing pass zeroes all 16384
// store entries with s_tready low; configuration writes are taken as ever.
module integer_value_counting_set
	import ivcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [VAL_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // value[15:0], rank[29:16], zero pad
	input  logic [REQ_W-1:0]     s_tuser,   // req_type[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // status[1:0], is_new[2], occurrences[34:3],
	                                        // found_value[50:35], distinct_seen[65:51], pad
);

	logic signed [VAL_W-1:0] value_min_q, value_max_q;
	logic                    out_free, res_valid;
	res_t                    res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_min_q <= VALUE_MIN_RST;
			value_max_q <= VALUE_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_VALUE_MIN: value_min_q <= signed'(cfg_data);
				CFG_VALUE_MAX: value_max_q <= signed'(cfg_data);
			endcase
		end
	end

	ivcs_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.value_min(value_min_q),
		.value_max(value_max_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.req_type (s_tuser),
		.value    (signed'(s_tdata[VAL_W-1:0])),
		.rank     (s_tdata[VAL_W+RANK_W-1:VAL_W]),
		.out_free (out_free),
		.res_valid(res_valid),
		.res      (res)
	);

	ivcs_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> test/integer_value_counting_set_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_value_counting_set_tb
// Self-checking bench for the value counting set: adds, queries, rank selects
// and reserved requests over a series of windows, each result checked field by
// field against a local model of the count store, with random idling on both
// stream sides and one long output hold-off.
// ----------------------------------------------------------------------------
module integer_value_counting_set_tb;
	import ivcs_pkg::*;

	localparam int LIMIT_CYCLES = 2_000_000;

	// Local model of the count store; holds the expected results in order.
	class tally_scoreboard;
		logic [CNT_W-1:0]        slot_count [ENTRIES];
		logic [DIST_W-1:0]       distinct;
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		res_t                    expected_results [$];
		int                      errors;

		function new();
			foreach (slot_count[i])
				slot_count[i] = '0;
			distinct = '0;
			lo = VALUE_MIN_RST;
			hi = VALUE_MAX_RST;
			errors = 0;
		endfunction

		function void set_reg(logic idx, logic [VAL_W-1:0] data);
			if (idx == CFG_VALUE_MIN)
				lo = data;
			else
				hi = data;
		endfunction

		function int window_size();
			int span;
			span = int'(hi) - int'(lo) + 1;
			if (span <= 0)
				return 0;
			if (span > ENTRIES)
				return ENTRIES;
			return span;
		endfunction

		function void note_request(logic [REQ_W-1:0] req, logic signed [VAL_W-1:0] val,
				logic [RANK_W-1:0] rank);
			res_t r;
			int   size;
			int   off;
			int   slot;
			int   passed;
			int   i;
			bit   hit;
			r = '0;
			size = window_size();
			case (req)
				REQ_ADD, REQ_QUERY: begin
					off = int'(val) - int'(lo);
					if (off < 0 || off >= size) begin
						r.status = STAT_OUTSIDE;
					end else if (req == REQ_ADD) begin
						if (slot_count[off] == '0) begin
							r.is_new = 1'b1;
							if (distinct != DISTINCT_MAX)
								distinct++;
						end
						if (slot_count[off] != COUNT_MAX)
							slot_count[off]++;
						r.occurrences = slot_count[off];
					end else begin
						r.occurrences = slot_count[off];
					end
				end
				REQ_SELECT: begin
					hit = 1'b0;
					slot = 0;
					if (int'(distinct) < size) begin
						// walk the window, counting filled slots
						passed = 0;
						for (i = 0; i < size; i++) begin
							if (slot_count[i] != '0) begin
								passed++;
								if (passed == int'(rank) + 1) begin
									hit = 1'b1;
									slot = i;
									break;
								end
							end
						end
					end else if (int'(rank) < size) begin
						// every slot counted as filled: answer directly
						hit = 1'b1;
						slot = int'(rank);
					end
					if (hit)
						r.found_value = VAL_W'(int'(lo) + slot);
					else
						r.status = STAT_NOTFOUND;
				end
				default: ;
			endcase
			r.distinct_seen = distinct;
			expected_results.push_back(r);
		endfunction

		function void report(string field, longint want, longint got);
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			errors++;
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, got %h",
					$time, got);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.status != want.status)
				report("status", want.status, got.status);
			if (got.is_new != want.is_new)
				report("is_new", want.is_new, got.is_new);
			if (got.occurrences != want.occurrences)
				report("occurrences", want.occurrences, got.occurrences);
			if (got.found_value != want.found_value)
				report("found_value", want.found_value, got.found_value);
			if (got.distinct_seen != want.distinct_seen)
				report("distinct_seen", want.distinct_seen, got.distinct_seen);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic                 cfg_idx;
	logic [VAL_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;    // value[15:0], rank[29:16], zero pad
	logic [REQ_W-1:0]     s_tuser;    // req_type[1:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;    // status[1:0], is_new[2], occurrences[34:3],
	                                  // found_value[50:35], distinct_seen[65:51], pad

	tally_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int cycles = 0;

	integer_value_counting_set DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: long hold-off when asked, otherwise random stalls.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[M_RES_W-1:0]);
	end

	task automatic send_item(logic [REQ_W-1:0] req, logic signed [VAL_W-1:0] val,
			logic [RANK_W-1:0] rank);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {2'b00, rank, val};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(req, val, rank);
	endtask

	// Drop the offer so the last item is not taken again while waiting.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(logic signed [VAL_W-1:0] lo, logic signed [VAL_W-1:0] hi);
		drain();
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_VALUE_MIN;
		cfg_data <= lo;
		@(posedge clk);
		sb.set_reg(CFG_VALUE_MIN, lo);
		cfg_idx  <= CFG_VALUE_MAX;
		cfg_data <= hi;
		@(posedge clk);
		sb.set_reg(CFG_VALUE_MAX, hi);
		cfg_we <= 1'b0;
	endtask

	// Mostly in-window values and ranks near the distinct count; the rest noise.
	task automatic random_run(int n_items, int wide_rank_pct);
		int                      k;
		int                      size;
		int                      pick;
		logic [REQ_W-1:0]        req;
		logic signed [VAL_W-1:0] val;
		logic [RANK_W-1:0]       rank;
		for (k = 0; k < n_items; k++) begin
			size = sb.window_size();
			pick = $urandom_range(99);
			if (pick < 45)
				req = REQ_ADD;
			else if (pick < 70)
				req = REQ_QUERY;
			else if (pick < 92)
				req = REQ_SELECT;
			else
				req = REQ_RSVD;
			pick = $urandom_range(99);
			if (size > 0 && pick < 80)
				val = VAL_W'(int'(sb.lo) + $urandom_range(size - 1));
			else if (pick < 88)
				val = pick[0] ? VAL_W'(int'(sb.lo) - 1) : VAL_W'(int'(sb.hi) + 1);
			else
				val = VAL_W'($urandom);
			if ($urandom_range(99) < wide_rank_pct)
				rank = RANK_W'($urandom);
			else
				rank = RANK_W'($urandom_range(int'(sb.distinct) + 2));
			send_item(req, val, rank);
		end
	endtask

	initial begin
		sb = new();
		arst_n   <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_idx  <= CFG_VALUE_MIN;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= REQ_ADD;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset window
		send_item(REQ_SELECT, 16'sd0, 14'd0);       // empty store: rank not found
		send_item(REQ_QUERY, -16'sd5000, 14'd0);
		send_item(REQ_ADD, -16'sd5000, 14'd0);      // lowest slot
		send_item(REQ_ADD, 16'sd5000, 14'd0);       // highest slot
		send_item(REQ_ADD, 16'sd5000, 14'd0);
		send_item(REQ_ADD, -16'sd5001, 14'd0);      // just below window
		send_item(REQ_ADD, 16'sd5001, 14'd0);       // just above window
		send_item(REQ_QUERY, -16'sd32768, 14'd0);
		send_item(REQ_QUERY, 16'sd32767, 14'd0);
		send_item(REQ_ADD, 16'sd0, 14'd0);
		send_item(REQ_ADD, -16'sd1, 14'd0);
		send_item(REQ_QUERY, 16'sd5000, 14'd0);
		send_item(REQ_SELECT, 16'sd0, 14'd0);
		send_item(REQ_SELECT, 16'sd0, 14'd3);
		send_item(REQ_SELECT, 16'sd0, 14'd4);       // one past the last distinct value
		send_item(REQ_SELECT, 16'sd0, 14'h3FFF);
		send_item(REQ_RSVD, 16'sh7FFF, 14'h3FFF);
		send_item(REQ_RSVD, -16'sd32768, 14'd0);
		send_item(REQ_QUERY, -16'sd1, 14'd0);

		// small window: fills up and switches to direct select
		write_window(-16'sd8, 16'sd7);
		random_run(200, 30);

		write_window(16'sd100, 16'sd299);
		send_idle_pct = 57;
		random_run(250, 30);

		// window at the bottom of the value range
		write_window(-16'sd32768, -16'sd32705);
		send_idle_pct = 0;
		stall_pct = 57;
		random_run(250, 30);

		// window at the top of the value range
		write_window(16'sd32668, 16'sd32767);
		send_idle_pct = 25;
		stall_pct = 25;
		random_run(250, 30);

		// inverted window: nothing is inside
		write_window(16'sd32767, -16'sd32768);
		send_idle_pct = 0;
		stall_pct = 0;
		random_run(60, 30);

		// whole value range, clamped to the store depth; keep walks few
		write_window(-16'sd32768, 16'sd32767);
		send_idle_pct = 57;
		random_run(40, 10);

		// long output hold-off while items keep coming
		write_window(-16'sd20, 16'sd19);
		send_idle_pct = 0;
		hold_left = 300;
		random_run(250, 30);

		write_window(-16'sd1024, 16'sd1023);
		send_idle_pct = 25;
		stall_pct = 57;
		random_run(150, 10);

		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
rtl/ivcs_pkg.sv
rtl/ivcs_ram.sv
rtl/ivcs_core.sv
rtl/ivcs_out.sv
rtl/integer_value_counting_set.sv
test/integer_value_counting_set_tb.sv
